[hdl/slab_object_allocator_assert.svh]
// Assertion macros for the slab object allocator.
// Depends on nothing; included inside module bodies.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SOA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define SOA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hdl/soa_pkg.sv]
// Package for the slab object allocator: payload structs, codes, constants.
// No dependencies.
package soa_pkg;
	localparam int OBJ_MAX = 64;
	localparam logic [1:0] CLS_UNUSED  = 2'd0;
	localparam logic [1:0] CLS_EMPTY   = 2'd1;
	localparam logic [1:0] CLS_PARTIAL = 2'd2;
	localparam logic [1:0] CLS_FULL    = 2'd3;
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SLAB  = 3'd1;
	localparam logic [2:0] ST_BAD_SLAB = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_DOUBLE   = 3'd4;
	localparam logic       ACT_ALLOC   = 1'b0;
	localparam logic       ACT_FREE    = 1'b1;

	typedef struct packed {
		logic       action;
		logic [3:0] slab_id;
		logic [5:0] object_index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] given_slab;
		logic [5:0] given_index;
	} rsp_t;
endpackage

[hdl/soa_queue.sv]
// Two-entry request queue between the front end and the engine.
// Depends on soa_pkg.
module soa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  soa_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output soa_pkg::req_t  out_data
);
	import soa_pkg::*;
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (out_valid && out_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end
endmodule

[hdl/soa_engine.sv]
// Back end: slab tables, list links and the read-modify-write.
// Depends on soa_pkg and the assertion header.
module soa_engine #(
	parameter int SLABS = 16,
	parameter int SW = (SLABS > 1) ? $clog2(SLABS) : 1,
	parameter int LW = $clog2(SLABS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [6:0]    slot_cnt,
	input  logic          req_valid,
	output logic          req_ready,
	input  soa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output soa_pkg::rsp_t rsp
);
	import soa_pkg::*;
	`include "slab_object_allocator_assert.svh"

	localparam logic [LW-1:0] NUL = LW'(SLABS);

	logic [63:0]   occ_q  [SLABS];
	logic [6:0]    fre_q  [SLABS];
	logic [1:0]    cls_q  [SLABS];
	logic [LW-1:0] nxt_q  [SLABS];
	logic [LW-1:0] prv_q  [SLABS];
	logic [LW-1:0] head_q [3];

	logic          busy_q;
	req_t          req_s1;
	logic [SW-1:0] uslab_s1;
	logic          uhit_s1;

	// lowest unused slab
	logic [SW-1:0] uslab;
	logic          uhit;
	always_comb begin
		uslab = '0;
		uhit = 1'b0;
		for (int i = SLABS - 1; i >= 0; i--) begin
			if (cls_q[i] == CLS_UNUSED) begin
				uslab = SW'(i);
				uhit = 1'b1;
			end
		end
	end

	assign req_ready = !busy_q && !(rsp_valid && !rsp_ready);

	// busy state: decide
	logic          sel_ok, fresh;
	logic [SW-1:0] s;
	logic [63:0]   occ;
	logic [6:0]    fr;
	logic [1:0]    cl;
	logic [6:0]    idx;
	logic [2:0]    st;
	logic          do_move;
	logic [1:0]    ncls;
	logic [63:0]   nocc;
	logic [6:0]    nfr;
	always_comb begin
		fresh = 1'b0;
		sel_ok = 1'b1;
		s = '0;
		if (req_s1.action == ACT_ALLOC) begin
			if (head_q[CLS_PARTIAL-1] != NUL) s = head_q[CLS_PARTIAL-1][SW-1:0];
			else if (head_q[CLS_EMPTY-1] != NUL) s = head_q[CLS_EMPTY-1][SW-1:0];
			else begin
				s = uslab_s1;
				fresh = uhit_s1;
				sel_ok = uhit_s1;
			end
		end else begin
			s = SW'(req_s1.slab_id);
			sel_ok = {28'd0, req_s1.slab_id} < SLABS;
		end
		occ = fresh ? 64'd0 : occ_q[s];
		fr = fresh ? slot_cnt : fre_q[s];
		cl = cls_q[s];
		idx = 7'd64;
		for (int i = OBJ_MAX - 1; i >= 0; i--) begin
			if (!occ[i] && 7'(i) < slot_cnt) idx = 7'(i);
		end
		st = ST_OK;
		do_move = 1'b0;
		ncls = CLS_EMPTY;
		nocc = occ;
		nfr = fr;
		if (req_s1.action == ACT_ALLOC) begin
			if (!sel_ok || idx == 7'd64) st = ST_NO_SLAB;
			else begin
				nocc = occ | (64'd1 << idx[5:0]);
				nfr = (fr != 7'd0) ? fr - 7'd1 : fr;
				do_move = 1'b1;
				ncls = (nfr == 7'd0) ? CLS_FULL : CLS_PARTIAL;
			end
		end else begin
			if (!sel_ok || cl == CLS_UNUSED || fr >= slot_cnt) st = ST_BAD_SLAB;
			else if ({1'b0, req_s1.object_index} >= slot_cnt) st = ST_RANGE;
			else if (!occ[req_s1.object_index]) st = ST_DOUBLE;
			else begin
				nocc = occ & ~(64'd1 << req_s1.object_index);
				nfr = (fr != 7'd127) ? fr + 7'd1 : fr;
				if (nfr >= slot_cnt) begin
					do_move = 1'b1;
					ncls = CLS_EMPTY;
				end else if (fr == 7'd0) begin
					do_move = 1'b1;
					ncls = CLS_PARTIAL;
				end
			end
		end
	end

	// list update: unlink from old list (if any), push to front of new
	logic [1:0]    ocls;
	logic [LW-1:0] p, n, h;
	always_comb begin
		ocls = fresh ? CLS_UNUSED : cl;
		p = prv_q[s];
		n = nxt_q[s];
		h = head_q[ncls-1];
		if (ocls != CLS_UNUSED && ocls == ncls && h == LW'(s)) h = n;
	end

	always_ff @(posedge clk) begin
		if (busy_q && st == ST_OK) begin
			occ_q[s] <= nocc;
			fre_q[s] <= nfr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp_valid <= 1'b0;
			rsp <= '0;
			req_s1 <= '0;
			uslab_s1 <= '0;
			uhit_s1 <= 1'b0;
			for (int i = 0; i < SLABS; i++) begin
				cls_q[i] <= CLS_UNUSED;
				nxt_q[i] <= NUL;
				prv_q[i] <= NUL;
			end
			for (int i = 0; i < 3; i++) head_q[i] <= NUL;
		end else begin
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
				req_s1 <= req;
				uslab_s1 <= uslab;
				uhit_s1 <= uhit;
			end
			if (busy_q) begin
				busy_q <= 1'b0;
				rsp_valid <= 1'b1;
				rsp.status <= st;
				rsp.given_slab <= (st == ST_OK && req_s1.action == ACT_ALLOC) ? 4'(s) : 4'd0;
				rsp.given_index <= (st == ST_OK && req_s1.action == ACT_ALLOC) ? idx[5:0] : 6'd0;
				if (st == ST_OK && do_move) begin
					if (ocls != CLS_UNUSED) begin
						if (p != NUL) nxt_q[p[SW-1:0]] <= n;
						else head_q[ocls-1] <= n;
						if (n != NUL) prv_q[n[SW-1:0]] <= p;
					end
					if (h != NUL && h != LW'(s)) prv_q[h[SW-1:0]] <= LW'(s);
					else if (h != NUL && ocls != CLS_UNUSED && n != NUL && n == h)
						prv_q[h[SW-1:0]] <= LW'(s);
					cls_q[s] <= ncls;
					prv_q[s] <= NUL;
					nxt_q[s] <= h;
					head_q[ncls-1] <= LW'(s);
				end
			end
		end
	end

	`SOA_ASSERT_NXT(a_busy_one, clk, arst_n, busy_q, !busy_q && rsp_valid, "busy over one cycle")
	`SOA_ASSERT_IMP(a_no_take_busy, clk, arst_n, busy_q, !req_ready, "took request while busy")
	`SOA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
		"result dropped")
endmodule

[hdl/slab_object_allocator.sv]
// Slab object allocator top: front end, request queue and engine.
// Depends on soa_pkg, soa_queue and soa_engine.
// Path: request registered into the engine, decided while busy, result registered,
// plus queue wait. No new request is taken while busy or while a result is held.
// Reset: all slabs unused, lists empty, slot count 32; no clearing pass.
module slab_object_allocator #(
	parameter int SLABS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  soa_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output soa_pkg::rsp_t out_data
);
	import soa_pkg::*;
	logic [6:0] ops_q;
	logic [6:0] slot_cnt;
	logic       qv, qr;
	req_t       qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ops_q <= 7'd32;
		else if (cfg_we) ops_q <= cfg_wdata;
	end

	// clamp to the valid slot range
	assign slot_cnt = (ops_q < 7'd2) ? 7'd2 : (ops_q > 7'(OBJ_MAX)) ? 7'(OBJ_MAX) : ops_q;

	soa_queue u_queue (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid(qv), .out_ready(qr), .out_data(qd)
	);

	soa_engine #(.SLABS(SLABS)) u_engine (
		.clk, .arst_n, .slot_cnt,
		.req_valid(qv), .req_ready(qr), .req(qd),
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data)
	);
endmodule
